@@ sv/diff_drive_odometry_integrator_top_assert.svh @@
// Assertion macros for the odometry integrator
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// same-cycle implication
`define ODO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ODO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/odo_pkg.sv @@
// Shared constants, types and the arctangent table for the odometry integrator
package odo_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic [31:0] CORDIC_START = 32'd652032874;
  localparam logic [14:0] INV_PI_Q16   = 15'd20861;
  localparam logic [23:0] INV_BASE_RST = 24'd131072;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  function automatic logic [31:0] cordic_atan(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2FA;
      default: v = 32'h0000517D;
    endcase
    return v;
  endfunction

endpackage

@@ sv/odo_if.sv @@
// Valid/ready channel interfaces for wheel samples and pose results
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] left_speed;
  logic signed [23:0] right_speed;
  logic        [15:0] elapsed;
  modport source (output valid, left_speed, right_speed, elapsed, input ready);
  modport sink   (input valid, left_speed, right_speed, elapsed, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [16:0] heading;
  logic signed [23:0] fwd_speed;
  logic signed [31:0] turn_rate;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, pos_x, pos_y, heading, fwd_speed, turn_rate, quat_z, quat_w,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, fwd_speed, turn_rate, quat_z, quat_w,
                  output ready);
endinterface

@@ sv/odo_mul.sv @@
// Shared signed multiplier with registered product
module odo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end
endmodule

@@ sv/odo_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle
module odo_cordic import odo_pkg::*; #(
  parameter int unsigned Steps = CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic        [31:0] angle,
  output cordic_stat_t       stat,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  localparam int CntW = (Steps > 1) ? $clog2(Steps) : 1;

  logic signed [33:0] x_r, y_r, z_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r, done_r, flip_r;
  logic               flip_s;
  logic [31:0]        a_s;
  logic signed [33:0] dx, dy, at, xs, ys;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767)       return 16'sh7FFF;
    else if (v < -34'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  always_comb begin
    flip_s = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    a_s    = flip_s ? (angle + 32'h8000_0000) : angle;
    dx     = y_r >>> cnt_r;
    dy     = x_r >>> cnt_r;
    at     = {2'b00, cordic_atan(4'(cnt_r))};
    xs     = x_r >>> 15;
    ys     = y_r >>> 15;
    if (flip_r) begin
      xs = -xs;
      ys = -ys;
    end
    cos_q = sat16(xs);
    sin_q = sat16(ys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        flip_r <= flip_s;
        x_r    <= {2'b00, CORDIC_START};
        y_r    <= '0;
        z_r    <= {{2{a_s[31]}}, a_s};
      end else if (busy_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        if (cnt_r == CntW'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

@@ sv/diff_drive_odometry_integrator_top.sv @@
// Top level of the differential-drive odometry integrator
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | left_speed, right_speed, elapsed
//  out_ch  | out | valid/ready      | pos_x, pos_y, heading, fwd_speed, turn_rate, quat_z/w
//  cfg_*   | in  | write enable     | inv_wheel_base (24 bit)
//
// Each item needs two passes through the single CORDIC plus seven trips through the
// shared multiplier. in_ch.ready is high only while the sequencer idles; a finished
// result sits in the output register, so a new item is taken while it waits.
// Completion stalls if the previous result is still untaken. Reset is synchronous:
// pose clears, base = 1/0.5 m.
`include "diff_drive_odometry_integrator_top_assert.svh"
module diff_drive_odometry_integrator_top import odo_pkg::*; #(
  parameter int unsigned CordicSteps = CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  odo_in_if.sink      in_ch,
  odo_out_if.source   out_ch
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TURN = 4'd1;  // product diff*inv
  localparam logic [3:0] ST_DTK  = 4'd2;  // saturate turn, dt*K
  localparam logic [3:0] ST_TH   = 4'd3;  // turn*(dt*K)
  localparam logic [3:0] ST_HD   = 4'd4;  // wait first CORDIC
  localparam logic [3:0] ST_CDT  = 4'd5;  // cos*dt
  localparam logic [3:0] ST_CF   = 4'd6;  // *fwd
  localparam logic [3:0] ST_SDT  = 4'd7;  // x update, sin*dt
  localparam logic [3:0] ST_SF   = 4'd8;  // *fwd
  localparam logic [3:0] ST_Y    = 4'd9;  // y and heading update, CORDIC for half angle
  localparam logic [3:0] ST_C2   = 4'd10; // wait CORDIC
  localparam logic [3:0] ST_OUT  = 4'd11; // load result register
  localparam logic [3:0] ST_HS   = 4'd12; // capture heading step

  logic [3:0]         state_r, state_nxt;
  logic [23:0]        inv_r;
  logic signed [23:0] fwd_r;
  logic signed [24:0] diff_r;
  logic        [15:0] dt_r;
  logic signed [31:0] turn_r, acc_x_r, acc_y_r;
  logic        [16:0] acc_hd_r, hd_step_r, hd_new;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic               cs_start;
  logic        [31:0] cs_angle;
  cordic_stat_t       cs_stat;
  logic signed [15:0] cs_sin, cs_cos;
  logic signed [24:0] lr_sum;
  logic               out_valid_r, out_load, in_take;
  logic signed [33:0] pos_sum;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -50'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  odo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  odo_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .angle(cs_angle),
    .stat(cs_stat), .sin_q(cs_sin), .cos_q(cs_cos)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign lr_sum      = 25'(in_ch.left_speed) + 25'(in_ch.right_speed);
  assign hd_new      = acc_hd_r + hd_step_r;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // position accumulator add, x or y depending on state; product term is signed
  always_comb begin
    if (state_r == ST_SDT) pos_sum = 34'(acc_x_r) + 34'($signed(prod_r[63:31]));
    else                   pos_sum = 34'(acc_y_r) + 34'($signed(prod_r[63:31]));
  end

  always_comb begin
    cs_start = 1'b0;
    cs_angle = {acc_hd_r[15:0], 16'h0000};
    if (in_take) cs_start = 1'b1;
    if (state_r == ST_Y) begin
      cs_start = 1'b1;
      cs_angle = {hd_new, 15'h0000};
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r) inside
      ST_TURN: begin mul_a = 33'(diff_r); mul_b = {9'd0, inv_r}; end
      ST_DTK:  begin mul_a = {17'd0, dt_r}; mul_b = {18'd0, INV_PI_Q16}; end
      ST_TH:   begin mul_a = 33'(turn_r); mul_b = prod_r[32:0]; end
      ST_CDT:  begin mul_a = {17'd0, dt_r}; mul_b = 33'(cs_cos); end
      ST_CF, ST_SF: begin mul_a = prod_r[32:0]; mul_b = 33'(fwd_r); end
      ST_SDT:  begin mul_a = {17'd0, dt_r}; mul_b = 33'(cs_sin); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_TURN;
      ST_TURN: state_nxt = ST_DTK;
      ST_DTK:  state_nxt = ST_TH;
      ST_TH:   state_nxt = ST_HS;
      ST_HS:   state_nxt = ST_HD;
      ST_HD:   if (!cs_stat.busy) state_nxt = ST_CDT;
      ST_CDT:  state_nxt = ST_CF;
      ST_CF:   state_nxt = ST_SDT;
      ST_SDT:  state_nxt = ST_SF;
      ST_SF:   state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_C2;
      ST_C2:   if (cs_stat.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inv_r       <= INV_BASE_RST;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_hd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) inv_r <= cfg_wdata;
      if (in_take) begin
        fwd_r  <= lr_sum[24:1];
        diff_r <= 25'(in_ch.right_speed) - 25'(in_ch.left_speed);
        dt_r   <= in_ch.elapsed;
      end
      if (state_r == ST_DTK) turn_r <= sat32(prod_r[65:16]);
      // product is valid only in the cycle right after ST_TH
      if (state_r == ST_HS) hd_step_r <= prod_r[49:33];
      if (state_r == ST_SDT) acc_x_r <= sat32(50'(pos_sum));
      if (state_r == ST_Y) begin
        acc_y_r  <= sat32(50'(pos_sum));
        acc_hd_r <= hd_new;
      end
      if (out_load) begin
        out_valid_r      <= 1'b1;
        out_ch.pos_x     <= acc_x_r;
        out_ch.pos_y     <= acc_y_r;
        out_ch.heading   <= acc_hd_r;
        out_ch.fwd_speed <= fwd_r;
        out_ch.turn_rate <= turn_r;
        out_ch.quat_z    <= cs_sin;
        out_ch.quat_w    <= cs_cos;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;

  `ODO_ASSERT_NEXT(a_busy_after_take, in_take, !in_ch.ready, "ready high after an item")
  `ODO_ASSERT_IMPL(a_cordic_free, cs_start, !cs_stat.busy, "CORDIC restarted while busy")
  `ODO_ASSERT_IMPL(a_out_free, out_load, !out_valid_r || out_ch.ready, "result overwritten")
endmodule
